// ----- design/edd_pkg.sv -----
// Package for the edit distance engine: sizes, request codes, chain link types
// and the distance saturation helper. No dependencies.
`default_nettype none

package edd_pkg;

    localparam int MAX_LEN  = 64;
    localparam int VAL_W    = $clog2(MAX_LEN + 1);
    localparam int DIST_W   = 7;
    localparam int SYM_W    = 8;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_FINISH = 2'd3
    } t_req;

    // Data handed from one cell to the next along the row.
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] ch;
        logic [VAL_W-1:0] new_val;
        logic [VAL_W-1:0] old_val;
    } t_link;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [VAL_W-1:0] wr_pos;
        logic [SYM_W-1:0] wr_sym;
    } t_cell_ctl;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [VAL_W-1:0] v);
        logic [VAL_W+DIST_W-1:0] w;
        w = {{DIST_W{1'b0}}, v};
        if (w > (VAL_W + DIST_W)'(DIST_MAX)) begin
            return DIST_W'(DIST_MAX);
        end else begin
            return w[DIST_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/edd_cell.sv -----
// One cell of the row: holds one target character and one row entry.
// Depends on edd_pkg for the link and control types.
`default_nettype none

module edd_cell
    import edd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [VAL_W-1:0] i_index,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_link            i_link,
    output t_link                 o_link,
    output logic [VAL_W-1:0]      o_value
);

    logic [SYM_W-1:0] r_tchar;
    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    t_link            r_link;

    logic [VAL_W:0] c_above;
    logic [VAL_W:0] c_left;
    logic [VAL_W:0] c_diag;
    logic [VAL_W:0] c_min;

    always_comb begin
        c_above = {1'b0, r_value} + (VAL_W + 1)'(1);
        c_left  = {1'b0, i_link.new_val} + (VAL_W + 1)'(1);
        c_diag  = {1'b0, i_link.old_val} + ((r_tchar == i_link.ch) ? '0 : (VAL_W + 1)'(1));
        c_min   = (c_above < c_left) ? c_above : c_left;
        c_min   = (c_diag < c_min) ? c_diag : c_min;
        n_value = c_min[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        // The wave moves on with this cell's new entry and the entry it replaced.
        r_link.ch      <= i_link.ch;
        r_link.new_val <= n_value;
        r_link.old_val <= r_value;
        if (!i_rst_n) begin
            r_value      <= i_index;
            r_link.valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_value <= i_index;
            end else if (i_link.valid) begin
                r_value <= n_value;
            end
            r_link.valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_pos == i_index)) begin
            r_tchar <= i_ctl.wr_sym;
        end
    end

    assign o_link  = r_link;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- design/edit_distance_engine.sv -----
// Top level of the edit distance engine: request decode, row of cells, result register.
// Depends on edd_pkg and edd_cell.
//
// Usage: items arrive on the request channel (i_req_valid / o_req_ready) with a
// request type and a symbol. A start item clears both strings, append items add
// target characters, query items push one query character each through the row,
// and a finish item returns one item on the result channel (o_res_valid /
// i_res_ready) carrying the distance and the overflow flag.
// Each query character launches a wave that walks the row of MAX_LEN cells, one
// cell per cycle; waves are skewed, so a new query item is taken every cycle.
// Append items are also taken every cycle. Start and finish items wait until
// the last wave has left the row, and the result item appears in the cycle
// after the finish item is taken.
// The result register holds its item while the receiver stalls; a finish item
// is not taken while that register is full and not being emptied.
// Reset (synchronous, active low) clears both lengths and the overflow flag and
// loads entry i of the row with i, exactly as a start item does.
`default_nettype none

module edit_distance_engine
    import edd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [SYM_W-1:0]  i_symbol,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [DIST_W-1:0]      o_distance,
    output logic                   o_overflow
);

    logic [VAL_W-1:0]  r_tlen;
    logic [VAL_W-1:0]  r_qlen;
    logic              r_ovf;
    logic              r_res_valid;
    logic [DIST_W-1:0] r_res_dist;
    logic              r_res_ovf;

    t_req              req;
    logic              accept;
    logic              busy;
    logic              res_free;
    logic [MAX_LEN-1:0] wave_vec;
    logic [VAL_W-1:0]  sel_value;
    t_cell_ctl         cell_ctl;

    t_link             link [0:MAX_LEN];
    logic [VAL_W-1:0]  cell_val [1:MAX_LEN];

    assign req = t_req'(i_req_type);

    // A wave is still in the row while any cell output carries a valid query.
    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            wave_vec[k] = link[k + 1].valid;
        end
    end

    assign busy     = |wave_vec;
    assign res_free = !r_res_valid || i_res_ready;

    always_comb begin
        unique case (req)
            REQ_START:  o_req_ready = !busy;
            REQ_APPEND: o_req_ready = 1'b1;
            REQ_QUERY:  o_req_ready = 1'b1;
            REQ_FINISH: o_req_ready = !busy && res_free;
            default:    o_req_ready = 1'b0;
        endcase
    end

    assign accept = i_req_valid && o_req_ready;

    // Broadcast control: clear on start, write the next target position on append.
    always_comb begin
        cell_ctl.clear  = accept && (req == REQ_START);
        cell_ctl.wr_en  = accept && (req == REQ_APPEND) && (r_qlen == '0)
                          && (r_tlen != VAL_W'(MAX_LEN));
        cell_ctl.wr_pos = r_tlen + VAL_W'(1);
        cell_ctl.wr_sym = i_symbol;
    end

    // Entry 0 of the row always equals the query count, so it is not stored
    // separately: the wave starts with old entry 0 = qlen and new entry 0 = qlen + 1.
    always_comb begin
        link[0].valid   = accept && (req == REQ_QUERY) && (r_qlen != VAL_W'(MAX_LEN));
        link[0].ch      = i_symbol;
        link[0].new_val = r_qlen + VAL_W'(1);
        link[0].old_val = r_qlen;
    end

    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        edd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (VAL_W'(g)),
            .i_ctl   (cell_ctl),
            .i_link  (link[g - 1]),
            .o_link  (link[g]),
            .o_value (cell_val[g])
        );
    end

    assign sel_value = (r_tlen == '0) ? r_qlen : cell_val[r_tlen];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen <= '0;
            r_qlen <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            unique case (req)
                REQ_START: begin
                    r_tlen <= '0;
                    r_qlen <= '0;
                    r_ovf  <= 1'b0;
                end
                REQ_APPEND: begin
                    if (cell_ctl.wr_en) begin
                        r_tlen <= r_tlen + VAL_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                REQ_QUERY: begin
                    if (link[0].valid) begin
                        r_qlen <= r_qlen + VAL_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                REQ_FINISH: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: loaded on finish, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept && (req == REQ_FINISH)) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (req == REQ_FINISH)) begin
            r_res_dist <= sat_dist(sel_value);
            r_res_ovf  <= r_ovf;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_distance  = r_res_dist;
    assign o_overflow  = r_res_ovf;

endmodule

`default_nettype wire

// ----- tb/sv/edd_distance_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the edit distance engine: watches both channels, keeps its
// own copy of the string and row state, and compares every result item.
// Depends on edd_pkg for sizes and request codes.

module edd_distance_checker
    import edd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic [1:0]        i_req_type,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [DIST_W-1:0] i_distance,
    input  logic              i_overflow,
    output int                o_fail_count,
    output int                o_waiting
);

    typedef struct packed {
        logic [DIST_W-1:0] exp_dist;
        logic              dropped;
    } t_answer;

    logic [SYM_W-1:0] tgt_sym [MAX_LEN];
    int               cost_row [MAX_LEN+1];
    int               tgt_cnt;
    int               qry_cnt;
    logic             chars_dropped;
    t_answer          answers_due [$];
    int               fails;

    function automatic void clear_strings();
        for (int i = 0; i <= MAX_LEN; i++) begin
            cost_row[i] = i;
        end
        tgt_cnt       = 0;
        qry_cnt       = 0;
        chars_dropped = 1'b0;
    endfunction

    // One query character sweeps the row up to the target length, keeping the old
    // left-upper value as the diagonal term.
    function automatic void sweep_row(input logic [SYM_W-1:0] ch);
        int diag;
        int up;
        int best;
        diag = cost_row[0];
        qry_cnt++;
        cost_row[0] = qry_cnt;
        for (int i = 1; i <= tgt_cnt; i++) begin
            up   = cost_row[i];
            best = up + 1;
            if (cost_row[i-1] + 1 < best) begin
                best = cost_row[i-1] + 1;
            end
            if (diag + ((tgt_sym[i-1] == ch) ? 0 : 1) < best) begin
                best = diag + ((tgt_sym[i-1] == ch) ? 0 : 1);
            end
            cost_row[i] = best;
            diag = up;
        end
    endfunction

    function automatic t_answer current_answer();
        t_answer a;
        int      v;
        v          = cost_row[tgt_cnt];
        a.exp_dist = (v > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(v);
        a.dropped  = chars_dropped;
        return a;
    endfunction

    initial begin
        clear_strings();
        fails = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            clear_strings();
            answers_due.delete();
        end else begin
            // A result taken at this edge belongs to an earlier finish item.
            if (i_res_valid && i_res_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result: distance %0d, overflow %0d",
                           i_distance, i_overflow);
                    fails++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_distance !== want.exp_dist) begin
                        $error("distance mismatch: expected %0d, got %0d",
                               want.exp_dist, i_distance);
                        fails++;
                    end
                    if (i_overflow !== want.dropped) begin
                        $error("overflow mismatch: expected %0d, got %0d",
                               want.dropped, i_overflow);
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                case (i_req_type)
                    REQ_START: begin
                        clear_strings();
                    end
                    REQ_APPEND: begin
                        if (qry_cnt > 0 || tgt_cnt >= MAX_LEN) begin
                            chars_dropped = 1'b1;
                        end else begin
                            tgt_sym[tgt_cnt] = i_symbol;
                            tgt_cnt++;
                        end
                    end
                    REQ_QUERY: begin
                        if (qry_cnt >= MAX_LEN) begin
                            chars_dropped = 1'b1;
                        end else begin
                            sweep_row(i_symbol);
                        end
                    end
                    default: begin
                        answers_due.insert(answers_due.size(), current_answer());
                    end
                endcase
            end
        end
        o_waiting    <= answers_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/sv/tb_edit_distance_engine.sv -----
`timescale 1ns / 100ps
// Top of the edit distance engine testbench: clock, reset, request and result
// traffic, watchdog and verdict. Depends on edd_pkg, edit_distance_engine and
// edd_distance_checker.

module tb_edit_distance_engine;
    import edd_pkg::*;

    localparam int TOTAL_ITEMS    = 1850;
    localparam int QUIET_TAIL     = 150;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = MAX_LEN + 8;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic [1:0]        req_type  = REQ_START;
    logic [SYM_W-1:0]  symbol    = '0;
    logic              res_ready = 1'b0;
    logic              req_ready;
    logic              res_valid;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    int                n_fails;
    int                n_waiting;
    int                n_sent       = 0;
    int                stall_cycles = 0;

    // Shared traffic shaping: idle_on lets both sides insert random gaps,
    // hold_rx asks the result side for one long hold-off.
    bit                idle_on = 1'b1;
    bit                hold_rx = 1'b0;

    // Symbol source for one session: either the full byte range or a narrow
    // alphabet of three neighbors, so that matches are frequent.
    bit                sym_wide;
    logic [SYM_W-1:0]  sym_base;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    edit_distance_engine i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req_type  (req_type),
        .i_symbol    (symbol),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_distance  (distance),
        .o_overflow  (overflow)
    );

    edd_distance_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_type   (req_type),
        .i_symbol     (symbol),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_distance   (distance),
        .i_overflow   (overflow),
        .o_fail_count (n_fails),
        .o_waiting    (n_waiting)
    );

    // Result side. Each loop pass starts at an edge, so ready gets at most a
    // single nonblocking update per time step. A long hold-off, when asked
    // for, keeps ready low while the request side keeps offering finish
    // items; the result register fills and the engine stops taking them.
    always begin
        @(posedge clk);
        if (hold_rx) begin
            res_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
            hold_rx = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            res_ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clk);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // The watchdog only counts cycles in which neither channel moves an item.
    // The longest legal quiet stretch is the long hold-off plus a row drain.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_edit_distance_engine: errors");
            $finish;
        end
    end

    function automatic logic [SYM_W-1:0] pick_sym();
        if (sym_wide) begin
            return SYM_W'($urandom_range(0, 255));
        end
        return sym_base + SYM_W'($urandom_range(0, 2));
    endfunction

    // Offers one item and returns at the edge where it is taken. A gap, when
    // drawn, drops valid first; valid is never lowered in the step that raises
    // it, so back-to-back items keep valid high.
    task automatic send_item(input t_req kind, input logic [SYM_W-1:0] sym);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        symbol    <= sym;
        do @(posedge clk); while (!req_ready);
        n_sent++;
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(56, MAX_LEN + 4);
        end
        return $urandom_range(0, 8);
    endfunction

    // One well-formed session: start, target characters, query characters,
    // finish. Now and then the start is skipped, a stray item of any kind is
    // mixed into the query phase, an early finish peeks at the row, or the
    // finish is repeated. Long sessions run past the string capacity.
    task automatic run_session();
        int n_tgt;
        int n_qry;
        n_tgt    = pick_len();
        n_qry    = pick_len();
        sym_wide = ($urandom_range(0, 3) == 0);
        sym_base = SYM_W'($urandom_range(0, 253));
        if ($urandom_range(0, 9) != 0) begin
            send_item(REQ_START, SYM_W'($urandom));
        end
        for (int i = 0; i < n_tgt; i++) begin
            send_item(REQ_APPEND, pick_sym());
        end
        for (int i = 0; i < n_qry; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(t_req'($urandom_range(0, 3)), SYM_W'($urandom));
            end
            send_item(REQ_QUERY, pick_sym());
            if ($urandom_range(0, 19) == 0) begin
                send_item(REQ_FINISH, SYM_W'($urandom));
            end
        end
        send_item(REQ_FINISH, SYM_W'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            send_item(REQ_FINISH, SYM_W'($urandom));
        end
    endtask

    // Short session whose finish items pile up behind a long result hold-off.
    task automatic run_backpressure();
        send_item(REQ_START, 8'h00);
        send_item(REQ_APPEND, 8'h41);
        send_item(REQ_APPEND, 8'h42);
        send_item(REQ_APPEND, 8'h43);
        send_item(REQ_QUERY, 8'h42);
        send_item(REQ_QUERY, 8'h43);
        hold_rx = 1'b1;
        repeat (6) begin
            send_item(REQ_FINISH, 8'h00);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Empty strings right after reset give distance 0.
        send_item(REQ_FINISH, 8'hFF);
        // Target only: the distance is the target length.
        send_item(REQ_START, 8'hA5);
        send_item(REQ_APPEND, 8'h00);
        send_item(REQ_APPEND, 8'hFF);
        send_item(REQ_FINISH, 8'h00);
        // A target character after the first query character is dropped and
        // raises overflow; the extreme byte values meet each other here.
        send_item(REQ_QUERY, 8'hFF);
        send_item(REQ_APPEND, 8'h55);
        send_item(REQ_QUERY, 8'h00);
        send_item(REQ_QUERY, 8'hAA);
        send_item(REQ_FINISH, 8'h00);
        // Finish changes nothing, so a second one repeats the answer.
        send_item(REQ_FINISH, 8'h12);
        // Query only: the distance is the query length.
        send_item(REQ_START, 8'h00);
        send_item(REQ_QUERY, 8'h80);
        send_item(REQ_QUERY, 8'h7F);
        send_item(REQ_FINISH, 8'h00);
        // Start clears the overflow flag and both strings.
        send_item(REQ_START, 8'h00);
        send_item(REQ_FINISH, 8'h00);

        run_backpressure();

        // Random part. The last stretch runs with no idling on either side.
        while (n_sent < TOTAL_ITEMS) begin
            idle_on = (n_sent < TOTAL_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            run_session();
        end
        req_valid <= 1'b0;

        // Wait for every expected result, then let the row drain. The watchdog
        // bounds this wait if a result never comes.
        while (n_waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // A result that never arrived counts as a failure too.
        if (n_fails == 0 && n_waiting == 0) begin
            $display("tb_edit_distance_engine: clean");
        end else begin
            $display("tb_edit_distance_engine: errors");
        end
        $finish;
    end

endmodule
